### hdl/ses_pkg.sv
package ses_pkg;

  // Sequence states
  typedef enum logic [3:0] {
    ST_INACTIVE    = 4'd0,
    ST_IDLE        = 4'd1,
    ST_ARM_SOFT    = 4'd2,
    ST_SOFT        = 4'd3,
    ST_WAIT_FILTER = 4'd4,
    ST_ARM_HARD    = 4'd5,
    ST_HARD        = 4'd6,
    ST_DONE        = 4'd7,
    ST_ABORTED     = 4'd8,
    ST_FAULT       = 4'd9
  } seq_state_t;

  // Engine commands
  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_START_SOFT  = 3'd1,
    CMD_START_HARD  = 3'd2,
    CMD_PAUSE       = 3'd3,
    CMD_RESUME      = 3'd4,
    CMD_ABORT       = 3'd5,
    CMD_CLEAR_FAULT = 3'd6,
    CMD_ACK_DONE    = 3'd7
  } cmd_kind_t;

  // Measurement panel requests
  typedef enum logic [1:0] {
    MEAS_NONE    = 2'd0,
    MEAS_CAPTURE = 2'd1,
    MEAS_UNDO    = 2'd2
  } meas_req_t;

  // Item kinds
  localparam logic [1:0] OP_ACTION = 2'd0;
  localparam logic [1:0] OP_PHASE  = 2'd1;
  localparam logic [1:0] OP_ENTER  = 2'd2;
  localparam logic [1:0] OP_EXIT   = 2'd3;

  // User actions
  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_MEASURE = 3'd1;
  localparam logic [2:0] ACT_CONFIRM = 3'd2;
  localparam logic [2:0] ACT_PAUSE   = 3'd3;
  localparam logic [2:0] ACT_RESUME  = 3'd4;
  localparam logic [2:0] ACT_UNDO    = 3'd5;

  // Engine phases (code seven is stored but means nothing)
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PREWAIT  = 3'd1;
  localparam logic [2:0] PH_EXPOSING = 3'd2;
  localparam logic [2:0] PH_PAUSED   = 3'd3;
  localparam logic [2:0] PH_POSTWAIT = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;
  localparam logic [2:0] PH_FAULT    = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_TARGET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOSE_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_TIMEOUT  = 3'd5;

  localparam logic [15:0] ARM_TIMEOUT_RESET = 16'd200;
  localparam logic [15:0] MIN_START_TARGET  = 16'd10;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef struct packed {
    logic [15:0] soft_target;
    logic [15:0] hard_target;
    logic [15:0] presence_threshold;
    logic        dose_mode;
    logic        force_time;
    logic [15:0] arm_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  action;
    logic        on_measure_panel;
    logic        wireless_source;
    logic [2:0]  engine_phase;
    logic        fault_latched;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    seq_state_t  seq_state;
    logic [31:0] changed_at_ms;
    logic [2:0]  last_engine_phase;
  } seq_ctx_t;

  typedef struct packed {
    seq_state_t  seq_state;
    logic [31:0] state_age_ms;
    cmd_kind_t   cmd_kind;
    logic [15:0] cmd_target;
    logic        cmd_dose;
    meas_req_t   measure_request;
  } result_t;

endpackage

### hdl/ses_cfg_regs.sv
module ses_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ses_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                 cfg_data,
  output ses_pkg::cfg_t               cfg
);

  ses_pkg::cfg_t cfg_r;
  ses_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ses_pkg::CFG_SOFT_TARGET:  cfg_nxt.soft_target        = cfg_data;
        ses_pkg::CFG_HARD_TARGET:  cfg_nxt.hard_target        = cfg_data;
        ses_pkg::CFG_PRESENCE_THR: cfg_nxt.presence_threshold = cfg_data;
        ses_pkg::CFG_DOSE_MODE:    cfg_nxt.dose_mode          = cfg_data[0];
        ses_pkg::CFG_FORCE_TIME:   cfg_nxt.force_time         = cfg_data[0];
        ses_pkg::CFG_ARM_TIMEOUT:  cfg_nxt.arm_timeout_ms     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.soft_target        <= '0;
      cfg_r.hard_target        <= '0;
      cfg_r.presence_threshold <= '0;
      cfg_r.dose_mode          <= 1'b0;
      cfg_r.force_time         <= 1'b0;
      cfg_r.arm_timeout_ms     <= ses_pkg::ARM_TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hdl/ses_step.sv
module ses_step (
  input  ses_pkg::cfg_t     cfg,
  input  ses_pkg::item_t    item,
  input  ses_pkg::seq_ctx_t ctx,
  output ses_pkg::seq_ctx_t ctx_next,
  output ses_pkg::result_t  res
);

  logic [31:0]         elapsed;
  logic                soft_pres;
  logic                hard_pres;
  logic                busy;
  logic                restful;
  logic                eng_active;
  logic [15:0]         soft_clamp;
  logic [15:0]         hard_clamp;
  ses_pkg::seq_state_t soft_end;
  ses_pkg::seq_state_t af_state;
  ses_pkg::cmd_kind_t  af_cmd;
  logic [15:0]         af_tgt;
  ses_pkg::seq_state_t st;
  ses_pkg::seq_state_t st_n;
  logic [2:0]          ph_n;
  ses_pkg::cmd_kind_t  cmd;
  logic [15:0]         tgt;
  ses_pkg::meas_req_t  meas;
  logic                changed;

  always_comb begin
    st        = ctx.seq_state;
    elapsed   = item.now_ms - ctx.changed_at_ms;
    soft_pres = cfg.soft_target > cfg.presence_threshold;
    hard_pres = cfg.hard_target > cfg.presence_threshold;
    busy      = (st == ses_pkg::ST_ARM_SOFT) || (st == ses_pkg::ST_SOFT) ||
                (st == ses_pkg::ST_ARM_HARD) || (st == ses_pkg::ST_HARD);
    restful   = (st == ses_pkg::ST_IDLE) || (st == ses_pkg::ST_ABORTED) ||
                (st == ses_pkg::ST_DONE);
    eng_active = (item.engine_phase == ses_pkg::PH_PREWAIT) ||
                 (item.engine_phase == ses_pkg::PH_EXPOSING) ||
                 (item.engine_phase == ses_pkg::PH_PAUSED) ||
                 (item.engine_phase == ses_pkg::PH_POSTWAIT);
    soft_clamp = (cfg.soft_target < ses_pkg::MIN_START_TARGET) ?
                 ses_pkg::MIN_START_TARGET : cfg.soft_target;
    hard_clamp = (cfg.hard_target < ses_pkg::MIN_START_TARGET) ?
                 ses_pkg::MIN_START_TARGET : cfg.hard_target;
    soft_end   = hard_pres ? ses_pkg::ST_WAIT_FILTER : ses_pkg::ST_DONE;

    // After the filter change: start the hard part if there is one.
    if (hard_pres) begin
      af_state = ses_pkg::ST_ARM_HARD;
      af_cmd   = ses_pkg::CMD_START_HARD;
      af_tgt   = hard_clamp;
    end else begin
      af_state = ses_pkg::ST_DONE;
      af_cmd   = ses_pkg::CMD_NONE;
      af_tgt   = '0;
    end

    st_n = st;
    ph_n = ctx.last_engine_phase;
    cmd  = ses_pkg::CMD_NONE;
    tgt  = '0;
    meas = ses_pkg::MEAS_NONE;

    unique case (item.op)
      ses_pkg::OP_ENTER: begin
        ph_n = ses_pkg::PH_IDLE;
        st_n = ses_pkg::ST_IDLE;
      end
      ses_pkg::OP_EXIT: begin
        if (busy) begin
          cmd = ses_pkg::CMD_ABORT;
        end
        ph_n = ses_pkg::PH_IDLE;
        st_n = ses_pkg::ST_INACTIVE;
      end
      ses_pkg::OP_PHASE: begin
        if (st != ses_pkg::ST_INACTIVE) begin
          ph_n = item.engine_phase;
          if (item.engine_phase == ses_pkg::PH_FAULT) begin
            st_n = ses_pkg::ST_FAULT;
          end else begin
            unique case (st)
              ses_pkg::ST_ARM_SOFT: begin
                if (eng_active) begin
                  st_n = ses_pkg::ST_SOFT;
                end else if (item.engine_phase == ses_pkg::PH_DONE ||
                             (elapsed > {16'd0, cfg.arm_timeout_ms} &&
                              item.engine_phase == ses_pkg::PH_IDLE)) begin
                  st_n = soft_end;
                end
              end
              ses_pkg::ST_SOFT: begin
                if (item.engine_phase == ses_pkg::PH_DONE ||
                    item.engine_phase == ses_pkg::PH_IDLE) begin
                  st_n = soft_end;
                end
              end
              ses_pkg::ST_ARM_HARD: begin
                if (eng_active) begin
                  st_n = ses_pkg::ST_HARD;
                end else if (item.engine_phase == ses_pkg::PH_DONE ||
                             item.engine_phase == ses_pkg::PH_IDLE) begin
                  st_n = ses_pkg::ST_DONE;
                end
              end
              ses_pkg::ST_HARD: begin
                if (item.engine_phase == ses_pkg::PH_DONE ||
                    item.engine_phase == ses_pkg::PH_IDLE) begin
                  st_n = ses_pkg::ST_DONE;
                end
              end
              ses_pkg::ST_DONE: begin
                if (item.engine_phase == ses_pkg::PH_IDLE) begin
                  st_n = ses_pkg::ST_IDLE;
                end
              end
              ses_pkg::ST_FAULT: begin
                if (item.engine_phase == ses_pkg::PH_IDLE && !item.fault_latched) begin
                  st_n = ses_pkg::ST_ABORTED;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: begin
        if (st != ses_pkg::ST_INACTIVE) begin
          unique case (item.action)
            ses_pkg::ACT_START: begin
              if (item.on_measure_panel) begin
                meas = ses_pkg::MEAS_CAPTURE;
              end else if (st == ses_pkg::ST_WAIT_FILTER) begin
                st_n = af_state;
                cmd  = af_cmd;
                tgt  = af_tgt;
              end else if (busy) begin
                if (ctx.last_engine_phase == ses_pkg::PH_EXPOSING) begin
                  cmd = ses_pkg::CMD_PAUSE;
                end else if (ctx.last_engine_phase == ses_pkg::PH_PAUSED) begin
                  cmd = ses_pkg::CMD_RESUME;
                end
              end else if (restful) begin
                if (soft_pres) begin
                  cmd  = ses_pkg::CMD_START_SOFT;
                  tgt  = soft_clamp;
                  st_n = ses_pkg::ST_ARM_SOFT;
                end else if (hard_pres) begin
                  cmd  = ses_pkg::CMD_START_HARD;
                  tgt  = hard_clamp;
                  st_n = ses_pkg::ST_ARM_HARD;
                end
              end else if (st == ses_pkg::ST_FAULT) begin
                cmd  = ses_pkg::CMD_CLEAR_FAULT;
                st_n = ses_pkg::ST_ABORTED;
              end
            end
            ses_pkg::ACT_MEASURE: begin
              if (st == ses_pkg::ST_FAULT) begin
                cmd  = ses_pkg::CMD_CLEAR_FAULT;
                st_n = ses_pkg::ST_ABORTED;
              end else if (item.on_measure_panel && !item.wireless_source) begin
                meas = ses_pkg::MEAS_CAPTURE;
              end
            end
            ses_pkg::ACT_CONFIRM: begin
              if (st == ses_pkg::ST_WAIT_FILTER) begin
                st_n = af_state;
                cmd  = af_cmd;
                tgt  = af_tgt;
              end else if (st == ses_pkg::ST_DONE) begin
                cmd  = ses_pkg::CMD_ACK_DONE;
                st_n = ses_pkg::ST_IDLE;
              end
            end
            ses_pkg::ACT_PAUSE: begin
              if (busy) begin
                cmd = ses_pkg::CMD_PAUSE;
              end
            end
            ses_pkg::ACT_RESUME: begin
              if (busy) begin
                cmd = ses_pkg::CMD_RESUME;
              end
            end
            ses_pkg::ACT_UNDO: begin
              if (item.on_measure_panel && restful) begin
                meas = ses_pkg::MEAS_UNDO;
              end else if (busy) begin
                cmd  = ses_pkg::CMD_ABORT;
                st_n = ses_pkg::ST_ABORTED;
              end else if (st == ses_pkg::ST_WAIT_FILTER) begin
                cmd  = ses_pkg::CMD_ACK_DONE;
                st_n = ses_pkg::ST_ABORTED;
              end else if (st == ses_pkg::ST_DONE) begin
                cmd  = ses_pkg::CMD_ACK_DONE;
                st_n = ses_pkg::ST_IDLE;
              end else if (st == ses_pkg::ST_FAULT) begin
                cmd  = ses_pkg::CMD_CLEAR_FAULT;
                st_n = ses_pkg::ST_ABORTED;
              end else if (st == ses_pkg::ST_ABORTED) begin
                st_n = ses_pkg::ST_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
    endcase

    // Timestamp only on a real state change.
    changed = (st_n != st);
    ctx_next.seq_state         = st_n;
    ctx_next.last_engine_phase = ph_n;
    ctx_next.changed_at_ms     = changed ? item.now_ms : ctx.changed_at_ms;

    res.seq_state       = st_n;
    res.state_age_ms    = (st_n == ses_pkg::ST_INACTIVE || changed) ? 32'd0 : elapsed;
    res.cmd_kind        = cmd;
    res.cmd_target      = tgt;
    res.cmd_dose        = (cmd != ses_pkg::CMD_NONE) && cfg.dose_mode && !cfg.force_time;
    res.measure_request = meas;
  end

endmodule

### hdl/split_exposure_sequencer_unit.sv
// Split exposure sequencer: soft then hard exposure, one result per item.
// Pipeline: an input transfer is held in the input register, then the state update
//   fills the result register and out_tvalid rises.
// Throughput: 1 item per cycle while the receiver takes results, set by the state update loop.
// Reset (rst_n low, synchronous): sequence inactive, last phase idle, change time
//   zero, configuration at reset values (arm timeout 200 ms), both stages empty.
module split_exposure_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst_n,

  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata, low bit up: action[2:0], on_measure_panel[3], wireless_source[4],
  //   engine_phase[7:5], fault_latched[8], now_ms[40:9], zero fill [47:41]
  input  logic [ses_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: op[1:0]
  input  logic [1:0]                      in_tuser,

  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata, low bit up: seq_state[3:0], state_age_ms[35:4], cmd_kind[38:36],
  //   cmd_target[54:39], cmd_dose[55], measure_request[57:56], zero fill [63:58]
  output logic [ses_pkg::OUT_TDATA_W-1:0] out_tdata,

  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ses_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);

  ses_pkg::cfg_t     cfg;
  ses_pkg::item_t    item_in;

  logic              in_valid_r;
  ses_pkg::item_t    in_item_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  ses_pkg::result_t  out_res_r;
  ses_pkg::seq_ctx_t ctx_r;
  ses_pkg::seq_ctx_t ctx_nxt;
  ses_pkg::result_t  step_res;
  logic              advance;

  ses_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the input transfer.
  always_comb begin
    item_in.op               = in_tuser;
    item_in.action           = in_tdata[2:0];
    item_in.on_measure_panel = in_tdata[3];
    item_in.wireless_source  = in_tdata[4];
    item_in.engine_phase     = in_tdata[7:5];
    item_in.fault_latched    = in_tdata[8];
    item_in.now_ms           = in_tdata[40:9];
  end

  // Advance the held item into the result register when that slot is free
  // or drains this cycle. The input register refills in the same cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  ses_step u_step (
    .cfg      (cfg),
    .item     (in_item_r),
    .ctx      (ctx_r),
    .ctx_next (ctx_nxt),
    .res      (step_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r              <= 1'b0;
      out_valid_r             <= 1'b0;
      ctx_r.seq_state         <= ses_pkg::ST_INACTIVE;
      ctx_r.changed_at_ms     <= '0;
      ctx_r.last_engine_phase <= ses_pkg::PH_IDLE;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        ctx_r <= ctx_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= item_in;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0,
                       out_res_r.measure_request,
                       out_res_r.cmd_dose,
                       out_res_r.cmd_target,
                       out_res_r.cmd_kind,
                       out_res_r.state_age_ms,
                       out_res_r.seq_state};

endmodule

### hdl/ses_checker.sv
module ses_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ses_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Inactive sequence reports zero age.
  a_inactive_age: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] == ses_pkg::ST_INACTIVE |-> out_tdata[35:4] == 32'd0)
    else $error("inactive state with nonzero age");

  // No command means no target and no dose flag.
  a_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[38:36] == ses_pkg::CMD_NONE
    |-> out_tdata[54:39] == 16'd0 && !out_tdata[55])
    else $error("payload on empty command");

  // Start commands carry a clamped target and enter an arming state.
  a_start_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[38:36] == ses_pkg::CMD_START_SOFT ||
                   out_tdata[38:36] == ses_pkg::CMD_START_HARD)
    |-> out_tdata[54:39] >= ses_pkg::MIN_START_TARGET &&
        (out_tdata[3:0] == ses_pkg::ST_ARM_SOFT || out_tdata[3:0] == ses_pkg::ST_ARM_HARD))
    else $error("bad start command");

endmodule

bind split_exposure_sequencer_unit ses_checker u_ses_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ses_pkg::*;

  // Codes the package leaves unnamed: an action that does nothing, an unused
  // action code, and the spare engine phase code that is stored but ignored.
  localparam logic [2:0] ACT_OTHER  = 3'd6;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [2:0] PH_SPARE   = 3'd7;

  // Generous bound: it covers about 1500 transfers, random idling on both sides and
  // one long receiver hold-off.
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // tdata, low bit up: action, on_measure_panel, wireless_source, engine_phase,
  //   fault_latched, now_ms, zero fill
  logic [IN_TDATA_W-1:0]  in_tdata;
  // tuser: op
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // tdata, low bit up: seq_state, state_age_ms, cmd_kind, cmd_target, cmd_dose,
  //   measure_request, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [15:0]            cfg_data;

  split_exposure_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the sequencer: configuration, state and per-item outputs.
  logic [15:0] reg_soft;
  logic [15:0] reg_hard;
  logic [15:0] reg_thr;
  logic        reg_dose;
  logic        reg_force;
  logic [15:0] reg_timeout;
  seq_state_t  seq_now;
  logic [31:0] changed_at;
  logic [2:0]  last_phase;
  cmd_kind_t   pend_cmd;
  logic [15:0] pend_target;
  meas_req_t   pend_meas;

  // Results still owed by the block, oldest first
  result_t     expected_results[$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic [31:0] wall_ms;     // running millisecond clock fed as now_ms
  bit          no_idle;     // suppress random idling on both sides
  int unsigned hold_req;    // receiver hold-off request, in cycles
  int unsigned hold_left;

  // ---------------------------------------------------------------------------
  // Sequencer prediction
  // ---------------------------------------------------------------------------

  // Restart the age only on a real state change
  function automatic void move_to(seq_state_t nxt, logic [31:0] now);
    if (seq_now != nxt) begin
      seq_now = nxt;
      changed_at = now;
    end
  endfunction

  function automatic bit soft_present();
    return reg_soft > reg_thr;
  endfunction

  function automatic bit hard_present();
    return reg_hard > reg_thr;
  endfunction

  function automatic bit exposure_busy();
    return seq_now == ST_ARM_SOFT || seq_now == ST_SOFT ||
           seq_now == ST_ARM_HARD || seq_now == ST_HARD;
  endfunction

  function automatic bit engine_running(logic [2:0] ph);
    return ph == PH_PREWAIT || ph == PH_EXPOSING || ph == PH_PAUSED || ph == PH_POSTWAIT;
  endfunction

  // Issue a start with the target clamped to the minimum and arm that part
  function automatic void start_part(bit hard, logic [31:0] now);
    logic [15:0] tgt;
    tgt = hard ? reg_hard : reg_soft;
    if (tgt < MIN_START_TARGET) tgt = MIN_START_TARGET;
    pend_cmd = hard ? CMD_START_HARD : CMD_START_SOFT;
    pend_target = tgt;
    move_to(hard ? ST_ARM_HARD : ST_ARM_SOFT, now);
  endfunction

  // Filter changed: go on with the hard part, or finish when there is none
  function automatic void leave_filter_wait(logic [31:0] now);
    if (hard_present()) start_part(1'b1, now);
    else move_to(ST_DONE, now);
  endfunction

  function automatic void clear_fault(logic [31:0] now);
    pend_cmd = CMD_CLEAR_FAULT;
    move_to(ST_ABORTED, now);
  endfunction

  function automatic void take_phase(logic [2:0] ph, logic fl, logic [31:0] now);
    seq_state_t  soft_end;
    logic [31:0] elapsed;
    soft_end = hard_present() ? ST_WAIT_FILTER : ST_DONE;
    elapsed = now - changed_at;
    last_phase = ph;
    if (ph == PH_FAULT) begin
      move_to(ST_FAULT, now);
    end else begin
      case (seq_now)
        ST_ARM_SOFT: begin
          // an idle report only ends arming once the timeout has passed
          if (engine_running(ph)) move_to(ST_SOFT, now);
          else if (ph == PH_DONE || (elapsed > {16'd0, reg_timeout} && ph == PH_IDLE))
            move_to(soft_end, now);
        end
        ST_SOFT: if (ph == PH_DONE || ph == PH_IDLE) move_to(soft_end, now);
        ST_ARM_HARD: begin
          if (engine_running(ph)) move_to(ST_HARD, now);
          else if (ph == PH_DONE || ph == PH_IDLE) move_to(ST_DONE, now);
        end
        ST_HARD: if (ph == PH_DONE || ph == PH_IDLE) move_to(ST_DONE, now);
        ST_DONE: if (ph == PH_IDLE) move_to(ST_IDLE, now);
        ST_FAULT: if (ph == PH_IDLE && !fl) move_to(ST_ABORTED, now);
        default: ;
      endcase
    end
  endfunction

  function automatic void take_action(logic [2:0] act, logic panel, logic wireless,
                                      logic [31:0] now);
    bit restful;
    restful = seq_now == ST_IDLE || seq_now == ST_ABORTED || seq_now == ST_DONE;
    case (act)
      ACT_START: begin
        if (panel) pend_meas = MEAS_CAPTURE;
        else if (seq_now == ST_WAIT_FILTER) leave_filter_wait(now);
        else if (exposure_busy()) begin
          // start toggles pause and resume while the engine runs
          if (last_phase == PH_EXPOSING) pend_cmd = CMD_PAUSE;
          else if (last_phase == PH_PAUSED) pend_cmd = CMD_RESUME;
        end else if (restful) begin
          if (soft_present()) start_part(1'b0, now);
          else if (hard_present()) start_part(1'b1, now);
        end else if (seq_now == ST_FAULT) clear_fault(now);
      end
      ACT_MEASURE: begin
        if (seq_now == ST_FAULT) clear_fault(now);
        else if (panel && !wireless) pend_meas = MEAS_CAPTURE;
      end
      ACT_CONFIRM: begin
        if (seq_now == ST_WAIT_FILTER) leave_filter_wait(now);
        else if (seq_now == ST_DONE) begin
          pend_cmd = CMD_ACK_DONE;
          move_to(ST_IDLE, now);
        end
      end
      ACT_PAUSE:  if (exposure_busy()) pend_cmd = CMD_PAUSE;
      ACT_RESUME: if (exposure_busy()) pend_cmd = CMD_RESUME;
      ACT_UNDO: begin
        if (panel && restful) pend_meas = MEAS_UNDO;
        else if (exposure_busy()) begin
          pend_cmd = CMD_ABORT;
          move_to(ST_ABORTED, now);
        end else if (seq_now == ST_WAIT_FILTER) begin
          pend_cmd = CMD_ACK_DONE;
          move_to(ST_ABORTED, now);
        end else if (seq_now == ST_DONE) begin
          pend_cmd = CMD_ACK_DONE;
          move_to(ST_IDLE, now);
        end else if (seq_now == ST_FAULT) clear_fault(now);
        else if (seq_now == ST_ABORTED) move_to(ST_IDLE, now);
      end
      default: ;
    endcase
  endfunction

  // Advance the shadow state by one item and return the result it owes
  function automatic result_t sequence_step(item_t it);
    result_t r;
    pend_cmd = CMD_NONE;
    pend_target = '0;
    pend_meas = MEAS_NONE;
    case (it.op)
      OP_ENTER: begin
        last_phase = PH_IDLE;
        move_to(ST_IDLE, it.now_ms);
      end
      OP_EXIT: begin
        if (exposure_busy()) pend_cmd = CMD_ABORT;
        last_phase = PH_IDLE;
        move_to(ST_INACTIVE, it.now_ms);
      end
      default: begin
        // user actions and phase reports are dropped while inactive
        if (seq_now != ST_INACTIVE) begin
          if (it.op == OP_PHASE) take_phase(it.engine_phase, it.fault_latched, it.now_ms);
          else take_action(it.action, it.on_measure_panel, it.wireless_source, it.now_ms);
        end
      end
    endcase
    r = '0;
    r.seq_state = seq_now;
    r.state_age_ms = (seq_now == ST_INACTIVE) ? 32'd0 : it.now_ms - changed_at;
    r.cmd_kind = pend_cmd;
    r.cmd_target = pend_target;
    r.cmd_dose = (pend_cmd != CMD_NONE) & reg_dose & ~reg_force;
    r.measure_request = pend_meas;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog and result checking
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISMATCHES)
      $display("mismatch on %s at %0t: expected %0h, actual %0h", field, $realtime, want, got);
  endtask

  // Compare one result transfer, field by field, with the oldest expectation
  task automatic check_result(logic [OUT_TDATA_W-1:0] bus);
    result_t want;
    if (expected_results.size() == 0) begin
      note_mismatch("result with none expected", 64'd0, bus);
      return;
    end
    want = expected_results.pop_front();
    if (bus[3:0] !== want.seq_state)
      note_mismatch("seq_state", 64'(want.seq_state), 64'(bus[3:0]));
    if (bus[35:4] !== want.state_age_ms)
      note_mismatch("state_age_ms", 64'(want.state_age_ms), 64'(bus[35:4]));
    if (bus[38:36] !== want.cmd_kind)
      note_mismatch("cmd_kind", 64'(want.cmd_kind), 64'(bus[38:36]));
    if (bus[54:39] !== want.cmd_target)
      note_mismatch("cmd_target", 64'(want.cmd_target), 64'(bus[54:39]));
    if (bus[55] !== want.cmd_dose)
      note_mismatch("cmd_dose", 64'(want.cmd_dose), 64'(bus[55]));
    if (bus[57:56] !== want.measure_request)
      note_mismatch("measure_request", 64'(want.measure_request), 64'(bus[57:56]));
  endtask

  // Receiver: check each result transfer, then pick tready for the next edge.
  // A hold-off request loads a counter that keeps tready low until it runs out.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration
  // ---------------------------------------------------------------------------

  // Offer one item, idling at random first; predict its result at the transfer.
  // Leave tvalid high on return so back-to-back items stay back to back.
  task automatic send_item(logic [1:0] op, logic [2:0] act, logic panel, logic wireless,
                           logic [2:0] ph, logic fl, logic [31:0] now);
    item_t it;
    it.op = op;
    it.action = act;
    it.on_measure_panel = panel;
    it.wireless_source = wireless;
    it.engine_phase = ph;
    it.fault_latched = fl;
    it.now_ms = now;
    while (!no_idle && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'd0, now, fl, ph, wireless, panel, act};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(sequence_step(it));
  endtask

  // Drop tvalid and hold until every owed result has come
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; cfg_valid stays high for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SOFT_TARGET:  reg_soft = val;
      CFG_HARD_TARGET:  reg_hard = val;
      CFG_PRESENCE_THR: reg_thr = val;
      CFG_DOSE_MODE:    reg_dose = val[0];
      CFG_FORCE_TIME:   reg_force = val[0];
      CFG_ARM_TIMEOUT:  reg_timeout = val;
      default: ;
    endcase
  endtask

  // Reprogram every register; call only with the block drained
  task automatic program_setting(logic [15:0] soft_tgt, logic [15:0] hard, logic [15:0] thr,
                                 logic dose, logic force_t, logic [15:0] timeout);
    write_reg(CFG_SOFT_TARGET, soft_tgt);
    write_reg(CFG_HARD_TARGET, hard);
    write_reg(CFG_PRESENCE_THR, thr);
    write_reg(CFG_DOSE_MODE, {15'd0, dose});
    write_reg(CFG_FORCE_TIME, {15'd0, force_t});
    write_reg(CFG_ARM_TIMEOUT, timeout);
    cfg_valid <= 1'b0;
  endtask

  // One item: mostly the step a real exposure would take from the current
  // state, with random content; about a fifth is pure noise.
  task automatic drive_guided_item();
    logic [1:0]  op;
    logic [2:0]  act;
    logic [2:0]  ph;
    logic        panel;
    logic        wireless;
    logic        fl;
    int unsigned pick;
    // advance time: mostly small steps, sometimes past the arm timeout, rarely a jump
    if ($urandom_range(0, 199) == 0) wall_ms = $urandom;
    else if ($urandom_range(0, 19) == 0) wall_ms += $urandom_range(0, 70000);
    else wall_ms += $urandom_range(0, 120);

    if ($urandom_range(0, 99) < 20) begin
      send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 32'($urandom) : wall_ms);
      return;
    end

    op = OP_ACTION;
    act = ACT_START;
    ph = PH_IDLE;
    panel = ($urandom_range(0, 9) == 0);
    wireless = 1'($urandom_range(0, 1));
    fl = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    case (seq_now)
      ST_INACTIVE: begin
        if (pick < 85) op = OP_ENTER;
        else act = 3'($urandom_range(0, 7));
      end
      ST_IDLE, ST_ABORTED, ST_DONE: begin
        if (pick < 55) act = ACT_START;
        else if (pick < 70) act = ACT_CONFIRM;
        else if (pick < 80) act = ACT_UNDO;
        else if (pick < 88) act = ACT_MEASURE;
        else if (pick < 96) op = OP_PHASE;
        else op = OP_EXIT;
      end
      ST_ARM_SOFT, ST_ARM_HARD: begin
        op = OP_PHASE;
        if (pick < 40) ph = ($urandom_range(0, 1) != 0) ? PH_PREWAIT : PH_EXPOSING;
        else if (pick < 60) ph = PH_IDLE;
        else if (pick < 75) ph = PH_DONE;
        else if (pick < 80) ph = PH_FAULT;
        else begin
          op = OP_ACTION;
          if (pick < 88) act = ($urandom_range(0, 1) != 0) ? ACT_PAUSE : ACT_RESUME;
          else if (pick < 95) act = ACT_START;
          else act = ACT_UNDO;
        end
      end
      ST_SOFT, ST_HARD: begin
        op = OP_PHASE;
        if (pick < 25) ph = PH_EXPOSING;
        else if (pick < 35) ph = PH_PAUSED;
        else if (pick < 45) ph = PH_POSTWAIT;
        else if (pick < 65) ph = PH_DONE;
        else if (pick < 72) ph = PH_IDLE;
        else if (pick < 76) ph = PH_FAULT;
        else if (pick < 96) begin
          op = OP_ACTION;
          if (pick < 86) act = ACT_START;
          else if (pick < 92) act = ($urandom_range(0, 1) != 0) ? ACT_PAUSE : ACT_RESUME;
          else act = ACT_UNDO;
        end else op = OP_EXIT;
      end
      ST_WAIT_FILTER: begin
        if (pick < 50) act = ACT_CONFIRM;
        else if (pick < 80) act = ACT_START;
        else if (pick < 90) act = ACT_UNDO;
        else begin
          op = OP_PHASE;
          ph = 3'($urandom_range(0, 7));
        end
      end
      ST_FAULT: begin
        if (pick < 50) op = OP_PHASE;
        else if (pick < 70) act = ACT_START;
        else if (pick < 85) act = ACT_MEASURE;
        else act = ACT_UNDO;
      end
      default: act = 3'($urandom_range(0, 7));
    endcase
    // start with the panel shown only captures, so keep it rare there
    if (op == OP_ACTION && act == ACT_START && seq_now != ST_INACTIVE)
      panel = ($urandom_range(0, 19) == 0);
    send_item(op, act, panel, wireless, ph, fl, wall_ms);
  endtask

  task automatic run_guided(int unsigned count);
    repeat (count) drive_guided_item();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk the corner cases by hand, then one complete soft and hard exposure
  task automatic test_directed_cases();
    wall_ms = 32'hFFFF_FF00;
    // inactive: actions and phase reports change nothing, exit too
    send_item(OP_ACTION, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_FAULT, 1'b1, wall_ms);
    send_item(OP_EXIT, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_ENTER, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    // reset targets: no part present, so start does nothing
    send_item(OP_ACTION, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_ACTION, ACT_OTHER, 1'b1, 1'b1, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_ACTION, ACT_UNUSED, 1'b1, 1'b1, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_SPARE, 1'b0, wall_ms);
    wall_ms += 5;
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_FAULT, 1'b1, wall_ms);
    // fault holds while latched, then aborts; age runs across the wrap
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, 32'h0000_0000);
    wall_ms = 32'h0000_0010;
    send_item(OP_ACTION, ACT_UNDO, 1'b1, 1'b0, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_ACTION, ACT_MEASURE, 1'b1, 1'b1, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_ACTION, ACT_MEASURE, 1'b1, 1'b0, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_ENTER, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    wait_for_drain();

    // full-scale soft target, hard target below the start minimum
    program_setting(16'hFFFF, 16'd5, 16'd4, 1'b1, 1'b0, ARM_TIMEOUT_RESET);
    wall_ms += 3;
    send_item(OP_ACTION, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    // idle report right at the timeout keeps arming, one ms later ends it
    wall_ms += 32'(ARM_TIMEOUT_RESET);
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    wall_ms += 1;
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_ACTION, ACT_CONFIRM, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    // busy with the engine neither exposing nor paused: start does nothing
    send_item(OP_ACTION, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    wall_ms += 7;
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_EXPOSING, 1'b0, wall_ms);
    send_item(OP_ACTION, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_PAUSED, 1'b0, wall_ms);
    send_item(OP_ACTION, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    wall_ms += 900;
    send_item(OP_PHASE, ACT_START, 1'b0, 1'b0, PH_DONE, 1'b0, wall_ms);
    send_item(OP_ACTION, ACT_CONFIRM, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    // exit while arming aborts the engine
    send_item(OP_ACTION, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    send_item(OP_EXIT, ACT_START, 1'b0, 1'b0, PH_IDLE, 1'b0, wall_ms);
    wait_for_drain();
  endtask

  // Random exposures under a series of settings, extremes first
  task automatic test_config_sweep();
    for (int unsigned k = 0; k < 6; k++) begin
      case (k)
        0: program_setting(16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0);
        1: program_setting(16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b1, 1'b1, 16'hFFFF);
        2: program_setting(16'd3, 16'd800, 16'd2, 1'b1, 1'b0, ARM_TIMEOUT_RESET);
        3: program_setting(16'd0, 16'd7, 16'd0, 1'b1, 1'b0, 16'($urandom_range(0, 500)));
        4: program_setting(16'd1200, 16'd0, 16'd0, 1'b0, 1'b1, 16'd50);
        default: program_setting(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                                 16'($urandom_range(0, 2000)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 16'($urandom_range(0, 1000)));
      endcase
      // one whole setting runs without any idling on either side
      no_idle = (k == 2);
      run_guided(200);
      wait_for_drain();
      no_idle = 1'b0;
    end
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering
  task automatic test_receiver_holdoff();
    program_setting(16'd400, 16'd600, 16'd100, 1'b1, 1'b0, 16'd150);
    no_idle = 1'b1;
    hold_req = 400;
    run_guided(150);
    wait_for_drain();
    no_idle = 1'b0;
  endtask

  // Sender pauses until every owed result is back, then resumes
  task automatic test_sender_pause();
    run_guided(50);
    wait_for_drain();
    run_guided(50);
    wait_for_drain();
  endtask

  initial begin
    // known values on every input before the first edge
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 0;
    hold_left = 0;
    no_idle = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    wall_ms = '0;
    // shadow state after reset
    reg_soft = '0;
    reg_hard = '0;
    reg_thr = '0;
    reg_dose = 1'b0;
    reg_force = 1'b0;
    reg_timeout = ARM_TIMEOUT_RESET;
    seq_now = ST_INACTIVE;
    changed_at = '0;
    last_phase = PH_IDLE;
    pend_cmd = CMD_NONE;
    pend_target = '0;
    pend_meas = MEAS_NONE;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_config_sweep();
    test_receiver_holdoff();
    test_sender_pause();

    wait_for_drain();
    repeat (10) @(posedge clk);
    mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
